// ----- rtl/core/swm_pkg.sv -----
`timescale 1ns / 1ps
// swm_pkg: shared types and fixed constants for the sliding window median filter
// no dependencies; used by the cell, median stage and top level

package swm_pkg;

  // width of the window length register and its value after reset
  localparam int unsigned WLEN_BITS = 7;
  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd64;

  // per-cycle command broadcast to every cell of the sorted row
  typedef struct packed {
    logic update;  // cells take their next state this cycle
    logic ins;     // a new sample is inserted
    logic del;     // the oldest sample is dropped
  } cell_ctrl_t;

  // status a cell hands to its neighbors
  typedef struct packed {
    logic valid;   // cell holds a sample of the window
    logic gt;      // held sample is greater than the incoming one
    logic below;   // cell sits below the position being dropped, or nothing is dropped
  } cell_flags_t;

endpackage

// ----- rtl/core/sliding_window_median.sv -----
`timescale 1ns / 1ps
// sliding window median: a row of cells keeps the window sorted.
// a sample goes into the cell row, then the median select and output registers.
// one sample per cycle unless stalled, set by the single update step of the cell row.
// after the window length is cut below the fill, input stalls while the samples held
// beyond the new length are dropped; the oldest of the rest goes with the next sample.
// reset empties the window and sets the window length to 64.
// depends on swm_pkg, swm_cell and swm_median

module sliding_window_median import swm_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic        [WLEN_BITS-1:0]   cfg_wdata_i,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic signed [SAMPLE_BITS-1:0] median_value_o,
  output logic        [WLEN_BITS-1:0]   window_count_o
);

  localparam int IDX_BITS = $clog2(MAX_WINDOW);
  localparam int AGE_BITS = $clog2(MAX_WINDOW);
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int LEN_BITS = (CNT_BITS > WLEN_BITS) ? CNT_BITS : WLEN_BITS;

  logic [WLEN_BITS-1:0] window_len_q;
  logic [CNT_BITS-1:0]  fill_q, fill_d;
  logic                 row_valid_q;

  logic [LEN_BITS-1:0]  len_ext;
  logic [CNT_BITS-1:0]  len_eff;
  logic                 row_en, med_ready, trim_need, trim_act, accept, drop;
  cell_ctrl_t           ctrl;
  logic [AGE_BITS-1:0]  del_age;
  logic [IDX_BITS-1:0]  del_pos;
  logic                 del_any;

  cell_flags_t                   flags [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] values [MAX_WINDOW];
  logic        [AGE_BITS-1:0]    ages [MAX_WINDOW];
  logic        [MAX_WINDOW-1:0]  del_hit;

  // clamp the window length to 1..MAX_WINDOW
  always_comb begin
    len_ext = LEN_BITS'(window_len_q);
    if (len_ext == '0) begin
      len_ext = LEN_BITS'(1);
    end else if (len_ext > LEN_BITS'(MAX_WINDOW)) begin
      len_ext = LEN_BITS'(MAX_WINDOW);
    end
    len_eff = CNT_BITS'(len_ext);
  end

  assign row_en         = !row_valid_q || med_ready;
  assign trim_need      = fill_q > len_eff;
  assign trim_act       = trim_need && row_en;
  assign sample_stall_o = !row_en || trim_need;
  assign accept         = sample_valid_i && !sample_stall_o;
  assign drop           = trim_act || (accept && (fill_q == len_eff));

  always_comb begin
    ctrl.update = accept || trim_act;
    ctrl.ins    = accept;
    ctrl.del    = drop;
  end

  // the oldest sample always carries age fill-1
  assign del_age = AGE_BITS'(fill_q - CNT_BITS'(1));

  always_comb begin
    del_pos = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (del_hit[i]) del_pos = del_pos | IDX_BITS'(i);
    end
  end
  assign del_any = |del_hit;

  always_comb begin
    fill_d = fill_q;
    if (accept && !drop) begin
      fill_d = fill_q + CNT_BITS'(1);
    end else if (trim_act) begin
      fill_d = fill_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WLEN_RESET;
      fill_q       <= '0;
      row_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) window_len_q <= cfg_wdata_i;
      fill_q <= fill_d;
      if (accept) begin
        row_valid_q <= 1'b1;
      end else if (row_en) begin
        row_valid_q <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    cell_flags_t                   left_flags, right_flags;
    logic signed [SAMPLE_BITS-1:0] left_value, right_value;
    logic        [AGE_BITS-1:0]    left_age, right_age;

    if (g == 0) begin : g_head
      assign left_flags = '{valid: 1'b0, gt: 1'b0, below: 1'b1};
      assign left_value = '0;
      assign left_age   = '0;
    end else begin : g_mid
      assign left_flags = flags[g-1];
      assign left_value = values[g-1];
      assign left_age   = ages[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_tail
      assign right_flags = '0;
      assign right_value = '0;
      assign right_age   = '0;
    end else begin : g_body
      assign right_flags = flags[g+1];
      assign right_value = values[g+1];
      assign right_age   = ages[g+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS),
      .IDX_BITS    (IDX_BITS),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .sample_i      (sample_value_i),
      .del_age_i     (del_age),
      .del_pos_i     (del_pos),
      .del_none_i    (!del_any),
      .left_flags_i  (left_flags),
      .left_value_i  (left_value),
      .left_age_i    (left_age),
      .right_flags_i (right_flags),
      .right_value_i (right_value),
      .right_age_i   (right_age),
      .flags_o       (flags[g]),
      .value_o       (values[g]),
      .age_o         (ages[g]),
      .del_o         (del_hit[g])
    );
  end

  swm_median #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW),
    .CNT_BITS    (CNT_BITS),
    .IDX_BITS    (IDX_BITS)
  ) u_median (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (row_valid_q),
    .in_ready_o     (med_ready),
    .cell_value_i   (values),
    .count_i        (fill_q),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .median_value_o (median_value_o),
    .window_count_o (window_count_o)
  );

endmodule

// ----- rtl/core/swm_cell.sv -----
`timescale 1ns / 1ps
// swm_cell: one slot of the sorted window, holds a sample and its age
// depends on swm_pkg; instantiated in a row by sliding_window_median

module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_BITS    = 6,
  parameter int IDX_BITS    = 6,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_ctrl_t                    ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [AGE_BITS-1:0]    del_age_i,
  input  logic        [IDX_BITS-1:0]    del_pos_i,
  input  logic                          del_none_i,
  input  cell_flags_t                   left_flags_i,
  input  logic signed [SAMPLE_BITS-1:0] left_value_i,
  input  logic        [AGE_BITS-1:0]    left_age_i,
  input  cell_flags_t                   right_flags_i,
  input  logic signed [SAMPLE_BITS-1:0] right_value_i,
  input  logic        [AGE_BITS-1:0]    right_age_i,
  output cell_flags_t                   flags_o,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic        [AGE_BITS-1:0]    age_o,
  output logic                          del_o
);

  localparam bit IS_HEAD = (CELL_IDX == 0);

  logic                          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic        [AGE_BITS-1:0]    age_q, age_d;

  cell_flags_t                   my_flags;
  cell_flags_t                   cur_flags, prv_flags;
  logic signed [SAMPLE_BITS-1:0] cur_value, prv_value;
  logic        [AGE_BITS-1:0]    cur_age, prv_age;

  always_comb begin
    my_flags.valid = valid_q;
    my_flags.gt    = valid_q && (value_q > sample_i);
    my_flags.below = del_none_i || (IDX_BITS'(CELL_IDX) < del_pos_i);
  end

  assign flags_o = my_flags;
  assign value_o = value_q;
  assign age_o   = age_q;
  assign del_o   = ctrl_i.del && valid_q && (age_q == del_age_i);

  // row with the dropped entry squeezed out: slot i and slot i-1 of it
  always_comb begin
    if (my_flags.below) begin
      cur_flags = my_flags;
      cur_value = value_q;
      cur_age   = age_q;
    end else begin
      cur_flags = right_flags_i;
      cur_value = right_value_i;
      cur_age   = right_age_i;
    end
    if (left_flags_i.below) begin
      prv_flags = left_flags_i;
      prv_value = left_value_i;
      prv_age   = left_age_i;
    end else begin
      prv_flags = my_flags;
      prv_value = value_q;
      prv_age   = age_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    age_d   = age_q;
    if (ctrl_i.update) begin
      if (ctrl_i.ins) begin
        if (cur_flags.valid && !cur_flags.gt) begin
          // stays left of the new sample
          valid_d = 1'b1;
          value_d = cur_value;
          age_d   = cur_age + AGE_BITS'(1);
        end else if (prv_flags.valid && prv_flags.gt) begin
          // pushed one slot right by the new sample
          valid_d = 1'b1;
          value_d = prv_value;
          age_d   = prv_age + AGE_BITS'(1);
        end else if (IS_HEAD || (prv_flags.valid && !prv_flags.gt)) begin
          valid_d = 1'b1;
          value_d = sample_i;
          age_d   = '0;
        end else begin
          valid_d = 1'b0;
        end
      end else begin
        valid_d = cur_flags.valid;
        value_d = cur_value;
        age_d   = cur_age;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

endmodule

// ----- rtl/core/swm_median.sv -----
`timescale 1ns / 1ps
// swm_median: picks the two middle cells, averages them, output register
// depends on swm_pkg; fed by the cell row in sliding_window_median

module swm_median import swm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 64,
  parameter int CNT_BITS    = 7,
  parameter int IDX_BITS    = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] cell_value_i [MAX_WINDOW],
  input  logic        [CNT_BITS-1:0]    count_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic signed [SAMPLE_BITS-1:0] median_value_o,
  output logic        [WLEN_BITS-1:0]   window_count_o
);

  logic                          sel_valid_q;
  logic signed [SAMPLE_BITS-1:0] lo_q, hi_q;
  logic        [CNT_BITS-1:0]    sel_count_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] median_q;
  logic        [CNT_BITS-1:0]    out_count_q;

  logic                          sel_en, out_en;
  logic        [IDX_BITS-1:0]    idx_lo, idx_hi;
  logic        [CNT_BITS-1:0]    count_m1;
  logic        [SAMPLE_BITS-1:0] lo_sel, hi_sel;
  logic signed [SAMPLE_BITS:0]   pair_sum, pair_adj;

  assign out_en     = !out_valid_q || !result_stall_i;
  assign sel_en     = !sel_valid_q || out_en;
  assign in_ready_o = sel_en;

  // middle positions: (n-1)/2 and n/2, equal for an odd count
  assign count_m1 = count_i - CNT_BITS'(1);
  assign idx_lo   = IDX_BITS'(count_m1 >> 1);
  assign idx_hi   = IDX_BITS'(count_i >> 1);

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (idx_lo == IDX_BITS'(i)) lo_sel = lo_sel | cell_value_i[i];
      if (idx_hi == IDX_BITS'(i)) hi_sel = hi_sel | cell_value_i[i];
    end
  end

  // mean truncated toward zero: bump odd negative sums before the shift
  assign pair_sum = {lo_q[SAMPLE_BITS-1], lo_q} + {hi_q[SAMPLE_BITS-1], hi_q};
  assign pair_adj = pair_sum + (SAMPLE_BITS+1)'(pair_sum[SAMPLE_BITS] & pair_sum[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sel_en) sel_valid_q <= in_valid_i;
      if (out_en) out_valid_q <= sel_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_en && in_valid_i) begin
      lo_q        <= lo_sel;
      hi_q        <= hi_sel;
      sel_count_q <= count_i;
    end
    if (out_en && sel_valid_q) begin
      median_q    <= pair_adj[SAMPLE_BITS:1];
      out_count_q <= sel_count_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign median_value_o = median_q;
  assign window_count_o = WLEN_BITS'(out_count_q);

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench for sliding_window_median, directed table then random phases
// keeps its own sorted-window predictor; depends on swm_pkg and the block under test

module tb import swm_pkg::*;;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic [WLEN_BITS-1:0]       count;
  } median_result_t;

  // one row: optional window length write, the sample, and an optional typed-in result
  typedef struct packed {
    bit do_cfg;
    int cfg;
    int sample;
    bit typed;
    int median;
    int count;
  } directed_row_t;

  localparam int NUM_DIRECTED = 21;
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{0, 0,    32767, 1,  32767, 1},  // first sample after reset
    '{0, 0,   -32768, 1,      0, 2},  // mean of the extremes, truncated toward zero
    '{0, 0,        0, 1,      0, 3},
    '{1, 0,   -32768, 1, -32768, 1},  // zero length acts as one, window flushed
    '{0, 0,        5, 1,      5, 1},
    '{1, 1,       -1, 1,     -1, 1},
    '{1, 2,        7, 1,      3, 2},
    '{0, 0,       -3, 1,      2, 2},
    '{0, 0,       -4, 1,     -3, 2},  // negative odd sum rounds toward zero
    '{1, 127,    100, 1,     -3, 3},  // oversized length saturates
    '{0, 0,    32767, 1,     48, 4},
    '{0, 0,    32767, 1,    100, 5},
    '{1, 65,      -1, 0,      0, 0},
    '{1, 64,       0, 0,      0, 0},
    '{0, 0,        1, 0,      0, 0},
    '{1, 3,        2, 0,      0, 0},  // shrink below the fill
    '{0, 0,   -32768, 0,      0, 0},
    '{0, 0,    32767, 0,      0, 0},
    '{1, 64,      -1, 0,      0, 0},
    '{0, 0,       -1, 0,      0, 0},
    '{0, 0,        1, 0,      0, 0}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [WLEN_BITS-1:0]       cfg_wdata_i = '0;
  logic                       sample_valid_i = 1'b0;
  logic                       sample_stall_o;
  logic signed [SAMPLE_W-1:0] sample_value_i = '0;
  logic                       result_valid_o;
  logic                       result_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] median_value_o;
  logic [WLEN_BITS-1:0]       window_count_o;

  // predictor state
  int                   window_samples[$];
  logic [WLEN_BITS-1:0] window_len_q = WLEN_RESET;
  median_result_t       expected_medians[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;

  always #1 clk_i = ~clk_i;

  sliding_window_median #(
    .MAX_WINDOW (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_valid_i(sample_valid_i),
    .sample_stall_o(sample_stall_o),
    .sample_value_i(sample_value_i),
    .result_valid_o(result_valid_o),
    .result_stall_i(result_stall_i),
    .median_value_o(median_value_o),
    .window_count_o(window_count_o)
  );

  // drop oldest samples down to the effective length, append, take the median
  function automatic median_result_t window_step(logic signed [SAMPLE_W-1:0] s);
    int eff;
    int sorted[$];
    int tmp;
    int i;
    int j;
    int n;
    median_result_t r;
    eff = int'(window_len_q);
    if (eff == 0) eff = 1;
    if (eff > WINDOW_MAX) eff = WINDOW_MAX;
    while (window_samples.size() >= eff) void'(window_samples.pop_front());
    window_samples.push_back(int'(s));
    sorted = window_samples;
    n = sorted.size();
    for (i = 1; i < n; i++) begin
      tmp = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > tmp) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = tmp;
    end
    if (n % 2 == 1) begin
      r.median = SAMPLE_W'(sorted[n/2]);
    end else begin
      r.median = SAMPLE_W'((sorted[n/2-1] + sorted[n/2]) / 2);
    end
    r.count = WLEN_BITS'(n);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < 50) $display("mismatch @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_sample(int v, bit typed, median_result_t typed_r);
    median_result_t predicted;
    while (idle_on && $urandom_range(0, 99) < 20) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_value_i <= v[SAMPLE_W-1:0];
    do @(posedge clk_i); while (sample_stall_o);
    predicted = window_step(v[SAMPLE_W-1:0]);
    expected_medians.push_back(typed ? typed_r : predicted);
  endtask

  // register writes only once every pending transaction has drained
  task automatic write_window_len(int v);
    sample_valid_i <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[WLEN_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_len_q = v[WLEN_BITS-1:0];
  endtask

  // result side: check, then pick the next stall value
  initial begin
    median_result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_valid_o && !result_stall_i) begin
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("unexpected result median=%0d count=%0d",
                                    median_value_o, window_count_o));
        end else begin
          exp_r = expected_medians.pop_front();
          if (median_value_o !== exp_r.median)
            report_mismatch($sformatf("median got %0d want %0d", median_value_o, exp_r.median));
          if (window_count_o !== exp_r.count)
            report_mismatch($sformatf("count got %0d want %0d", window_count_o, exp_r.count));
        end
        results_seen++;
        // long hold-off so the block fills and pushes back on its input
        if (results_seen == 400 || results_seen == 1200) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall_i <= 1'b1;
        hold_left--;
      end else begin
        result_stall_i <= idle_on && ($urandom_range(0, 99) < 20);
      end
    end
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int row;
    int phase;
    int k;
    int len;
    int v;
    int last_v;
    median_result_t typed_r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < NUM_DIRECTED; row++) begin
      if (directed_rows[row].do_cfg) write_window_len(directed_rows[row].cfg);
      typed_r.median = SAMPLE_W'(directed_rows[row].median);
      typed_r.count  = WLEN_BITS'(directed_rows[row].count);
      send_sample(directed_rows[row].sample, directed_rows[row].typed, typed_r);
    end

    last_v = 0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: len = 64;
        1: len = 1;
        2: len = 127;
        3: len = 0;
        4: len = 2;
        5: len = 64;
        6: len = 5;
        7: len = 64;
        default: len = $urandom_range(1, 127);
      endcase
      write_window_len(len);
      // one phase runs flat out on both sides
      idle_on = (phase != 5);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: v = $signed(16'($urandom));
          5, 6, 7:       v = $urandom_range(0, 16) - 8;
          8: begin
            case ($urandom_range(0, 3))
              0: v = -32768;
              1: v = 32767;
              2: v = 0;
              default: v = -1;
            endcase
          end
          default: v = last_v;
        endcase
        last_v = v;
        send_sample(v, 1'b0, typed_r);
      end
    end
    idle_on = 1'b1;

    sample_valid_i <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
